// ===== hdl/virtio_tx_offload_header_parser_macros.svh =====
// assertion macros used by the checker
`ifndef VIRTIO_TX_OFFLOAD_HEADER_PARSER_MACROS_SVH
`define VIRTIO_TX_OFFLOAD_HEADER_PARSER_MACROS_SVH

// checked only outside reset
`define VTXO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define VTXO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== hdl/vtxo_pkg.sv =====
package vtxo_pkg;

  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  localparam logic [6:0] POS_MAX       = 7'd127;
  localparam logic [6:0] POS_ETYPE_HI  = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO  = 7'd13;
  localparam logic [6:0] POS_IETYPE_HI = 7'd16;
  localparam logic [6:0] POS_IETYPE_LO = 7'd17;
  localparam logic [6:0] L2_PLAIN      = 7'd14;
  localparam logic [6:0] L2_VLAN       = 7'd18;
  localparam logic [6:0] V4_PROTO_OFS  = 7'd9;
  localparam logic [6:0] TCP_DOFF_OFS  = 7'd12;
  localparam logic [6:0] V6_PROTO_OFS  = 7'd6;
  localparam logic [6:0] V6_DOFF_OFS   = 7'd52;
  localparam logic [5:0] V6_HDR_LEN    = 6'd40;

  localparam logic [7:0] FLAG_NEEDS_CSUM = 8'd1;
  localparam logic [6:0] GSO_TCPV4       = 7'd1;
  localparam logic [6:0] GSO_TCPV6       = 7'd4;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_SCTP = 8'd132;

  localparam logic [15:0] CSUM_OFS_TCP  = 16'd16;
  localparam logic [15:0] CSUM_OFS_UDP  = 16'd6;
  localparam logic [15:0] CSUM_OFS_SCTP = 16'd8;

  localparam logic [7:0] IHL_MASK  = 8'h0f;
  localparam logic [7:0] DOFF_MASK = 8'hf0;

  typedef enum logic [1:0] {
    IP_NONE = 2'd0,
    IP_V4   = 2'd1,
    IP_V6   = 2'd2
  } ip_kind_t;

  typedef enum logic [1:0] {
    CSUM_NONE = 2'd0,
    CSUM_TCP  = 2'd1,
    CSUM_UDP  = 2'd2,
    CSUM_SCTP = 2'd3
  } csum_kind_t;

  typedef struct packed {
    logic [7:0]  pkt_byte;
    logic        byte_last;
    logic [7:0]  hdr_flags;
    logic [7:0]  hdr_gso_type;
    logic [15:0] hdr_csum_start;
    logic [15:0] hdr_csum_offset;
    logic [15:0] hdr_gso_size;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  flags;
    logic [7:0]  seg_kind;
    logic [15:0] ck_start;
    logic [15:0] ck_ofs;
    logic [15:0] seg_size;
    logic        vlan;
    ip_kind_t    ip_kind;
    logic [3:0]  ihl_words;
    logic [7:0]  proto;
    logic [3:0]  doff_words;
  } frame_t;

  typedef struct packed {
    logic [4:0]  l2_length;
    logic [5:0]  l3_length;
    logic [5:0]  l4_length;
    ip_kind_t    ip_kind;
    csum_kind_t  csum_kind;
    logic        tso_on;
    logic [15:0] tso_segment_size;
    logic        gso_unsupported;
  } result_t;

endpackage

// ===== hdl/vtxo_fifo.sv =====
module vtxo_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  vtxo_pkg::frame_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vtxo_pkg::frame_t data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vtxo_pkg::frame_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign valid_o = (count_r != '0);
  assign data_o  = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

endmodule

// ===== hdl/vtxo_front.sv =====
module vtxo_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept_i,
  input  vtxo_pkg::byte_item_t item_i,
  output logic                 push_o,
  output vtxo_pkg::frame_t     frame_o
);

  logic [6:0]  pos_r, pos_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  seg_kind_r, seg_kind_nxt;
  logic [15:0] ck_start_r, ck_start_nxt;
  logic [15:0] ck_ofs_r, ck_ofs_nxt;
  logic [15:0] seg_size_r, seg_size_nxt;
  logic [15:0] ether_kind_r, ether_kind_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [3:0]  doff_r, doff_nxt;
  logic        vlan_r, vlan_nxt;

  logic [6:0]  l2;
  logic [15:0] etype_lo;
  logic [7:0]  b;
  logic        first;

  assign b        = item_i.pkt_byte;
  assign first    = (pos_r == '0);
  assign l2       = vlan_r ? vtxo_pkg::L2_VLAN : vtxo_pkg::L2_PLAIN;
  assign etype_lo = {ether_kind_r[15:8], b};

  // per-byte header capture
  always_comb begin
    flags_nxt      = first ? item_i.hdr_flags       : flags_r;
    seg_kind_nxt   = first ? item_i.hdr_gso_type    : seg_kind_r;
    ck_start_nxt   = first ? item_i.hdr_csum_start  : ck_start_r;
    ck_ofs_nxt     = first ? item_i.hdr_csum_offset : ck_ofs_r;
    seg_size_nxt   = first ? item_i.hdr_gso_size    : seg_size_r;
    ether_kind_nxt = ether_kind_r;
    vlan_nxt       = vlan_r;
    ihl_nxt        = ihl_r;
    proto_nxt      = proto_r;
    doff_nxt       = doff_r;
    pos_nxt        = (pos_r == vtxo_pkg::POS_MAX) ? pos_r : pos_r + 7'd1;

    priority if (pos_r == vtxo_pkg::POS_ETYPE_HI) begin
      ether_kind_nxt = {b, 8'h00};
    end else if (pos_r == vtxo_pkg::POS_ETYPE_LO) begin
      if (etype_lo == vtxo_pkg::ETH_VLAN) begin
        vlan_nxt       = 1'b1;
        ether_kind_nxt = '0;
      end else begin
        ether_kind_nxt = etype_lo;
      end
    end else if (vlan_r && pos_r == vtxo_pkg::POS_IETYPE_HI) begin
      ether_kind_nxt = {b, 8'h00};
    end else if (vlan_r && pos_r == vtxo_pkg::POS_IETYPE_LO) begin
      ether_kind_nxt = ether_kind_r | {8'h00, b};
    end

    if (pos_r >= l2) begin
      if (ether_kind_nxt == vtxo_pkg::ETH_IPV4) begin
        if (pos_r == l2) begin
          ihl_nxt = 4'(b & vtxo_pkg::IHL_MASK);
        end
        if (pos_r == l2 + vtxo_pkg::V4_PROTO_OFS) begin
          proto_nxt = b;
        end
        if (pos_r == l2 + {1'b0, ihl_nxt, 2'b00} + vtxo_pkg::TCP_DOFF_OFS) begin
          doff_nxt = 4'((b & vtxo_pkg::DOFF_MASK) >> 4);
        end
      end else if (ether_kind_nxt == vtxo_pkg::ETH_IPV6) begin
        if (pos_r == l2 + vtxo_pkg::V6_PROTO_OFS) begin
          proto_nxt = b;
        end
        if (pos_r == l2 + vtxo_pkg::V6_DOFF_OFS) begin
          doff_nxt = 4'((b & vtxo_pkg::DOFF_MASK) >> 4);
        end
      end
    end
  end

  // frame summary written into the queue for the back end
  always_comb begin
    frame_o.flags      = flags_nxt;
    frame_o.seg_kind   = seg_kind_nxt;
    frame_o.ck_start   = ck_start_nxt;
    frame_o.ck_ofs     = ck_ofs_nxt;
    frame_o.seg_size   = seg_size_nxt;
    frame_o.vlan       = vlan_nxt;
    frame_o.ihl_words  = ihl_nxt;
    frame_o.proto      = proto_nxt;
    frame_o.doff_words = doff_nxt;
    if (ether_kind_nxt == vtxo_pkg::ETH_IPV4) begin
      frame_o.ip_kind = vtxo_pkg::IP_V4;
    end else if (ether_kind_nxt == vtxo_pkg::ETH_IPV6) begin
      frame_o.ip_kind = vtxo_pkg::IP_V6;
    end else begin
      frame_o.ip_kind = vtxo_pkg::IP_NONE;
    end
  end

  assign push_o = accept_i && item_i.byte_last;

  always_ff @(posedge clk) begin
    if (!rst_n || push_o) begin
      pos_r        <= '0;
      flags_r      <= '0;
      seg_kind_r   <= '0;
      ck_start_r   <= '0;
      ck_ofs_r     <= '0;
      seg_size_r   <= '0;
      ether_kind_r <= '0;
      ihl_r        <= '0;
      proto_r      <= '0;
      doff_r       <= '0;
      vlan_r       <= 1'b0;
    end else if (accept_i) begin
      pos_r        <= pos_nxt;
      flags_r      <= flags_nxt;
      seg_kind_r   <= seg_kind_nxt;
      ck_start_r   <= ck_start_nxt;
      ck_ofs_r     <= ck_ofs_nxt;
      seg_size_r   <= seg_size_nxt;
      ether_kind_r <= ether_kind_nxt;
      ihl_r        <= ihl_nxt;
      proto_r      <= proto_nxt;
      doff_r       <= doff_nxt;
      vlan_r       <= vlan_nxt;
    end
  end

endmodule

// ===== hdl/vtxo_back.sv =====
module vtxo_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid_i,
  input  vtxo_pkg::frame_t  q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_pop_i,
  output vtxo_pkg::result_t result_o
);

  logic              valid_r, valid_nxt;
  vtxo_pkg::result_t result_r, result_nxt;
  logic              active;
  logic [4:0]        l2;
  logic [5:0]        l3;
  logic [7:0]        proto;
  logic [6:0]        gso_base;
  logic              csum_ok;

  assign q_pop_o = q_valid_i && (!valid_r || out_pop_i);

  // offload decision for one frame
  always_comb begin
    active   = (q_data_i.flags != '0) || (q_data_i.seg_kind != '0);
    l2       = q_data_i.vlan ? 5'(vtxo_pkg::L2_VLAN) : 5'(vtxo_pkg::L2_PLAIN);
    gso_base = q_data_i.seg_kind[6:0];
    l3       = '0;
    proto    = '0;
    if (q_data_i.ip_kind == vtxo_pkg::IP_V4) begin
      l3    = {q_data_i.ihl_words, 2'b00};
      proto = q_data_i.proto;
    end else if (q_data_i.ip_kind == vtxo_pkg::IP_V6) begin
      l3    = vtxo_pkg::V6_HDR_LEN;
      proto = q_data_i.proto;
    end
    csum_ok = (q_data_i.flags == vtxo_pkg::FLAG_NEEDS_CSUM) &&
              (q_data_i.ck_start == 16'(l2) + 16'(l3));

    result_nxt = '0;
    if (active) begin
      result_nxt.l2_length = l2;
      result_nxt.l3_length = l3;
      result_nxt.ip_kind   = q_data_i.ip_kind;
      if (csum_ok) begin
        priority if (q_data_i.ck_ofs == vtxo_pkg::CSUM_OFS_TCP &&
                     proto == vtxo_pkg::PROTO_TCP) begin
          result_nxt.csum_kind = vtxo_pkg::CSUM_TCP;
        end else if (q_data_i.ck_ofs == vtxo_pkg::CSUM_OFS_UDP &&
                     proto == vtxo_pkg::PROTO_UDP) begin
          result_nxt.csum_kind = vtxo_pkg::CSUM_UDP;
        end else if (q_data_i.ck_ofs == vtxo_pkg::CSUM_OFS_SCTP &&
                     proto == vtxo_pkg::PROTO_SCTP) begin
          result_nxt.csum_kind = vtxo_pkg::CSUM_SCTP;
        end else begin
          result_nxt.csum_kind = vtxo_pkg::CSUM_NONE;
        end
      end
      if (q_data_i.seg_kind != '0) begin
        if (gso_base == vtxo_pkg::GSO_TCPV4 || gso_base == vtxo_pkg::GSO_TCPV6) begin
          result_nxt.tso_on           = 1'b1;
          result_nxt.tso_segment_size = q_data_i.seg_size;
          if (q_data_i.ip_kind != vtxo_pkg::IP_NONE) begin
            result_nxt.l4_length = {q_data_i.doff_words, 2'b00};
          end
        end else begin
          result_nxt.gso_unsupported = 1'b1;
        end
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop_o) begin
      valid_nxt = 1'b1;
    end else if (out_pop_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid_o = valid_r;
  assign result_o    = result_r;

endmodule

// ===== hdl/virtio_tx_offload_header_parser.sv =====
// transmit offload header parser
//
// input queue side: one frame byte per transaction (push, full), starting at
// the destination mac; the virtio header fields are sampled on the first byte
// of each frame and in_byte_last marks the final byte.
// result queue side: one offload descriptor per frame (empty, pop); the
// oldest descriptor stays on the out_ ports while empty is low.
//
// throughput: one byte per cycle while full is low. a front end captures
// header fields as bytes pass; on the last byte it writes a frame summary
// into a queue of QUEUE_DEPTH entries. a back end turns each summary into a
// descriptor in its output register, one frame per cycle while that register
// is empty or popped. the summary enters the queue at the edge that takes
// the last byte, and the descriptor follows once the back end loads it.
// when the receiver stalls, the output register holds and the queue fills;
// full rises once QUEUE_DEPTH summaries wait, which stalls all input bytes.
// reset (synchronous, rst_n low) clears the frame state, the queue and the
// output register's valid flag; empty is high right after reset.
module virtio_tx_offload_header_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_byte_last,
  input  logic [7:0]  in_hdr_flags,
  input  logic [7:0]  in_hdr_gso_type,
  input  logic [15:0] in_hdr_csum_start,
  input  logic [15:0] in_hdr_csum_offset,
  input  logic [15:0] in_hdr_gso_size,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  out_l2_length,
  output logic [5:0]  out_l3_length,
  output logic [5:0]  out_l4_length,
  output logic [1:0]  out_ip_kind,
  output logic [1:0]  out_csum_kind,
  output logic        out_tso_on,
  output logic [15:0] out_tso_segment_size,
  output logic        out_gso_unsupported
);

  vtxo_pkg::byte_item_t item;
  vtxo_pkg::frame_t     frame_in;
  vtxo_pkg::frame_t     frame_out;
  vtxo_pkg::result_t    result;
  logic                 accept;
  logic                 frame_push;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  logic                 out_valid;

  assign item.pkt_byte        = in_pkt_byte;
  assign item.byte_last       = in_byte_last;
  assign item.hdr_flags       = in_hdr_flags;
  assign item.hdr_gso_type    = in_hdr_gso_type;
  assign item.hdr_csum_start  = in_hdr_csum_start;
  assign item.hdr_csum_offset = in_hdr_csum_offset;
  assign item.hdr_gso_size    = in_hdr_gso_size;

  assign full   = q_full;
  assign accept = push && !q_full;

  vtxo_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .item_i   (item),
    .push_o   (frame_push),
    .frame_o  (frame_in)
  );

  vtxo_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (frame_push),
    .data_i  (frame_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (frame_out)
  );

  vtxo_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_data_i    (frame_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .result_o    (result)
  );

  assign empty                = !out_valid;
  assign out_l2_length        = result.l2_length;
  assign out_l3_length        = result.l3_length;
  assign out_l4_length        = result.l4_length;
  assign out_ip_kind          = result.ip_kind;
  assign out_csum_kind        = result.csum_kind;
  assign out_tso_on           = result.tso_on;
  assign out_tso_segment_size = result.tso_segment_size;
  assign out_gso_unsupported  = result.gso_unsupported;

endmodule

// ===== hdl/vtxo_checker.sv =====
`include "virtio_tx_offload_header_parser_macros.svh"

module vtxo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [5:0]  out_l3_length,
  input logic [5:0]  out_l4_length,
  input logic [1:0]  out_ip_kind,
  input logic        out_tso_on,
  input logic [15:0] out_tso_segment_size,
  input logic        out_gso_unsupported
);

  logic held;
  logic seg_clear;
  logic non_ip;
  logic ip_len_clear;
  logic gso_clash;

  assign held         = !empty && !pop;
  assign seg_clear    = (out_tso_segment_size == '0) && (out_l4_length == '0);
  assign non_ip       = !empty && (out_ip_kind == vtxo_pkg::IP_NONE);
  assign ip_len_clear = (out_l3_length == '0) && (out_l4_length == '0);
  assign gso_clash    = out_tso_on && out_gso_unsupported;

  // result queue is empty the cycle after reset
  `VTXO_ASSERT_ALWAYS(a_empty_after_reset, !rst_n |=> empty, "result pending after reset")

  // a stalled descriptor stays pending with its segment size unchanged
  `VTXO_ASSERT(a_hold, held |=> !empty && $stable(out_tso_segment_size), "stall lost result")

  // segmentation fields only with tso
  `VTXO_ASSERT(a_tso_fields, !empty && !out_tso_on |-> seg_clear, "segment fields without tso")

  // no l3 or l4 length on a non-ip frame
  `VTXO_ASSERT(a_non_ip_len, non_ip |-> ip_len_clear, "lengths on non-ip frame")

  // tso and unsupported gso exclude each other
  `VTXO_ASSERT(a_gso_excl, !empty |-> !gso_clash, "tso with unsupported gso")

endmodule

bind virtio_tx_offload_header_parser vtxo_checker u_vtxo_checker (.*);

// ===== bench/virtio_tx_offload_header_parser_tb.sv =====
`timescale 1ns / 100ps

module virtio_tx_offload_header_parser_tb;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_pkt_byte = '0;
  logic        in_byte_last = 1'b0;
  logic [7:0]  in_hdr_flags = '0;
  logic [7:0]  in_hdr_gso_type = '0;
  logic [15:0] in_hdr_csum_start = '0;
  logic [15:0] in_hdr_csum_offset = '0;
  logic [15:0] in_hdr_gso_size = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  out_l2_length;
  logic [5:0]  out_l3_length;
  logic [5:0]  out_l4_length;
  logic [1:0]  out_ip_kind;
  logic [1:0]  out_csum_kind;
  logic        out_tso_on;
  logic [15:0] out_tso_segment_size;
  logic        out_gso_unsupported;

  virtio_tx_offload_header_parser i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_pkt_byte          (in_pkt_byte),
    .in_byte_last         (in_byte_last),
    .in_hdr_flags         (in_hdr_flags),
    .in_hdr_gso_type      (in_hdr_gso_type),
    .in_hdr_csum_start    (in_hdr_csum_start),
    .in_hdr_csum_offset   (in_hdr_csum_offset),
    .in_hdr_gso_size      (in_hdr_gso_size),
    .empty                (empty),
    .pop                  (pop),
    .out_l2_length        (out_l2_length),
    .out_l3_length        (out_l3_length),
    .out_l4_length        (out_l4_length),
    .out_ip_kind          (out_ip_kind),
    .out_csum_kind        (out_csum_kind),
    .out_tso_on           (out_tso_on),
    .out_tso_segment_size (out_tso_segment_size),
    .out_gso_unsupported  (out_gso_unsupported)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  vtxo_pkg::byte_item_t bytes_to_send[$];
  vtxo_pkg::result_t    descriptors_due[$];
  int                   drain_marks[$];
  int                   queued_bytes = 0;
  int                   sent_bytes = 0;
  int                   mismatches = 0;
  int                   idle_cycles = 0;
  int                   send_gap = 0;
  int                   send_calm = 0;
  int                   recv_stall = 0;
  int                   recv_calm = 0;
  logic                 holding;
  vtxo_pkg::byte_item_t cur_item;
  vtxo_pkg::result_t    due;

  // per-frame parser state
  logic [6:0]  frame_pos = '0;
  logic [7:0]  lat_flags = '0;
  logic [7:0]  lat_seg_kind = '0;
  logic [15:0] lat_ck_start = '0;
  logic [15:0] lat_ck_ofs = '0;
  logic [15:0] lat_seg_size = '0;
  logic [15:0] eth_type = '0;
  logic [3:0]  ihl_words = '0;
  logic [7:0]  ip_proto = '0;
  logic [3:0]  doff_words = '0;
  logic        has_vlan = 1'b0;

  task automatic track_frame_byte(input vtxo_pkg::byte_item_t it);
    int                pos;
    int                l2;
    int                l3;
    logic [15:0]       etype;
    logic [7:0]        proto;
    logic [6:0]        gso_kind;
    vtxo_pkg::result_t d;
    pos = int'(frame_pos);
    if (pos == 0) begin
      lat_flags    = it.hdr_flags;
      lat_seg_kind = it.hdr_gso_type;
      lat_ck_start = it.hdr_csum_start;
      lat_ck_ofs   = it.hdr_csum_offset;
      lat_seg_size = it.hdr_gso_size;
    end
    l2 = has_vlan ? int'(vtxo_pkg::L2_VLAN) : int'(vtxo_pkg::L2_PLAIN);
    if (pos == int'(vtxo_pkg::POS_ETYPE_HI)) begin
      eth_type = {it.pkt_byte, 8'h00};
    end else if (pos == int'(vtxo_pkg::POS_ETYPE_LO)) begin
      etype = eth_type | {8'h00, it.pkt_byte};
      if (etype == vtxo_pkg::ETH_VLAN) begin
        has_vlan = 1'b1;
        eth_type = '0;
      end else begin
        eth_type = etype;
      end
    end else if (has_vlan && pos == int'(vtxo_pkg::POS_IETYPE_HI)) begin
      eth_type = {it.pkt_byte, 8'h00};
    end else if (has_vlan && pos == int'(vtxo_pkg::POS_IETYPE_LO)) begin
      eth_type = eth_type | {8'h00, it.pkt_byte};
    end
    if (pos >= l2) begin
      if (eth_type == vtxo_pkg::ETH_IPV4) begin
        if (pos == l2) ihl_words = it.pkt_byte[3:0] & vtxo_pkg::IHL_MASK[3:0];
        if (pos == l2 + int'(vtxo_pkg::V4_PROTO_OFS)) ip_proto = it.pkt_byte;
        if (pos == l2 + 4 * int'(ihl_words) + int'(vtxo_pkg::TCP_DOFF_OFS))
          doff_words = 4'((it.pkt_byte & vtxo_pkg::DOFF_MASK) >> 4);
      end else if (eth_type == vtxo_pkg::ETH_IPV6) begin
        if (pos == l2 + int'(vtxo_pkg::V6_PROTO_OFS)) ip_proto = it.pkt_byte;
        if (pos == l2 + int'(vtxo_pkg::V6_DOFF_OFS))
          doff_words = 4'((it.pkt_byte & vtxo_pkg::DOFF_MASK) >> 4);
      end
    end
    if (frame_pos < vtxo_pkg::POS_MAX) frame_pos = frame_pos + 7'd1;

    if (it.byte_last) begin
      d = '0;
      if (lat_flags != 8'd0 || lat_seg_kind != 8'd0) begin
        l2 = has_vlan ? int'(vtxo_pkg::L2_VLAN) : int'(vtxo_pkg::L2_PLAIN);
        l3 = 0;
        proto = '0;
        d.l2_length = 5'(l2);
        if (eth_type == vtxo_pkg::ETH_IPV4) begin
          d.ip_kind = vtxo_pkg::IP_V4;
          l3 = 4 * int'(ihl_words);
          proto = ip_proto;
        end else if (eth_type == vtxo_pkg::ETH_IPV6) begin
          d.ip_kind = vtxo_pkg::IP_V6;
          l3 = int'(vtxo_pkg::V6_HDR_LEN);
          proto = ip_proto;
        end
        d.l3_length = 6'(l3);
        if (lat_flags == vtxo_pkg::FLAG_NEEDS_CSUM && int'(lat_ck_start) == l2 + l3) begin
          if (lat_ck_ofs == vtxo_pkg::CSUM_OFS_TCP && proto == vtxo_pkg::PROTO_TCP)
            d.csum_kind = vtxo_pkg::CSUM_TCP;
          else if (lat_ck_ofs == vtxo_pkg::CSUM_OFS_UDP && proto == vtxo_pkg::PROTO_UDP)
            d.csum_kind = vtxo_pkg::CSUM_UDP;
          else if (lat_ck_ofs == vtxo_pkg::CSUM_OFS_SCTP && proto == vtxo_pkg::PROTO_SCTP)
            d.csum_kind = vtxo_pkg::CSUM_SCTP;
        end
        if (lat_seg_kind != 8'd0) begin
          gso_kind = lat_seg_kind[6:0];
          if (gso_kind == vtxo_pkg::GSO_TCPV4 || gso_kind == vtxo_pkg::GSO_TCPV6) begin
            d.tso_on = 1'b1;
            d.tso_segment_size = lat_seg_size;
            d.l4_length = (d.ip_kind != vtxo_pkg::IP_NONE) ?
                          6'(4 * int'(doff_words)) : 6'd0;
          end else begin
            d.gso_unsupported = 1'b1;
          end
        end
      end
      descriptors_due.push_back(d);
      frame_pos    = '0;
      lat_flags    = '0;
      lat_seg_kind = '0;
      lat_ck_start = '0;
      lat_ck_ofs   = '0;
      lat_seg_size = '0;
      eth_type     = '0;
      ihl_words    = '0;
      ip_proto     = '0;
      doff_words   = '0;
      has_vlan     = 1'b0;
    end
  endtask

  function automatic vtxo_pkg::frame_t make_frame(logic [7:0] flags, logic [7:0] gso,
                                                  logic [15:0] cs_start, logic [15:0] cs_ofs,
                                                  logic [15:0] seg, logic vlan,
                                                  vtxo_pkg::ip_kind_t kind,
                                                  logic [3:0] ihl, logic [7:0] proto,
                                                  logic [3:0] doff);
    vtxo_pkg::frame_t f;
    f.flags      = flags;
    f.seg_kind   = gso;
    f.ck_start   = cs_start;
    f.ck_ofs     = cs_ofs;
    f.seg_size   = seg;
    f.vlan       = vlan;
    f.ip_kind    = kind;
    f.ihl_words  = ihl;
    f.proto      = proto;
    f.doff_words = doff;
    return f;
  endfunction

  task automatic queue_frame(input vtxo_pkg::frame_t f, input bit dbl, input int len);
    int                   i;
    int                   l2;
    int                   etype_pos;
    logic [7:0]           fb [256];
    vtxo_pkg::byte_item_t it;
    for (i = 0; i < 256; i++) fb[i] = 8'($urandom);
    l2 = f.vlan ? int'(vtxo_pkg::L2_VLAN) : int'(vtxo_pkg::L2_PLAIN);
    etype_pos = l2 - 2;
    if (f.vlan) begin
      fb[12] = vtxo_pkg::ETH_VLAN[15:8];
      fb[13] = vtxo_pkg::ETH_VLAN[7:0];
    end
    case (f.ip_kind)
      vtxo_pkg::IP_V4: begin
        {fb[etype_pos], fb[etype_pos + 1]} = vtxo_pkg::ETH_IPV4;
        fb[l2][3:0] = f.ihl_words;
        fb[l2 + 9] = f.proto;
        fb[l2 + 4 * int'(f.ihl_words) + 12][7:4] = f.doff_words;
      end
      vtxo_pkg::IP_V6: begin
        {fb[etype_pos], fb[etype_pos + 1]} = vtxo_pkg::ETH_IPV6;
        fb[l2 + 6] = f.proto;
        fb[l2 + 52][7:4] = f.doff_words;
      end
      default: begin
        if (dbl) {fb[etype_pos], fb[etype_pos + 1]} = vtxo_pkg::ETH_VLAN;
      end
    endcase
    for (i = 0; i < len; i++) begin
      it.pkt_byte  = fb[i];
      it.byte_last = (i == len - 1);
      if (i == 0) begin
        it.hdr_flags       = f.flags;
        it.hdr_gso_type    = f.seg_kind;
        it.hdr_csum_start  = f.ck_start;
        it.hdr_csum_offset = f.ck_ofs;
        it.hdr_gso_size    = f.seg_size;
      end else begin
        it.hdr_flags       = 8'($urandom);
        it.hdr_gso_type    = 8'($urandom);
        it.hdr_csum_start  = 16'($urandom);
        it.hdr_csum_offset = 16'($urandom);
        it.hdr_gso_size    = 16'($urandom);
      end
      bytes_to_send.push_back(it);
    end
    queued_bytes += len;
  endtask

  task automatic random_frame();
    logic               vlan;
    vtxo_pkg::ip_kind_t kind;
    logic [3:0]         ihl;
    logic [3:0]         doff;
    logic [7:0]         proto;
    logic [7:0]         flags;
    logic [7:0]         gso;
    logic [15:0]        cs_start;
    logic [15:0]        cs_ofs;
    int                 l2;
    int                 l3;
    int                 hdr_end;
    int                 len;
    int                 r;
    bit                 dbl;
    vlan = ($urandom_range(0, 3) == 0);
    l2 = vlan ? int'(vtxo_pkg::L2_VLAN) : int'(vtxo_pkg::L2_PLAIN);
    r = $urandom_range(0, 9);
    kind = (r < 5) ? vtxo_pkg::IP_V4 : (r < 8) ? vtxo_pkg::IP_V6 : vtxo_pkg::IP_NONE;
    dbl = vlan && kind == vtxo_pkg::IP_NONE && $urandom_range(0, 1) == 1;
    ihl = ($urandom_range(0, 1) == 1) ? 4'd5 : 4'($urandom_range(0, 15));
    doff = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: proto = vtxo_pkg::PROTO_TCP;
      1: proto = vtxo_pkg::PROTO_UDP;
      2: proto = vtxo_pkg::PROTO_SCTP;
      default: proto = 8'($urandom);
    endcase
    r = $urandom_range(0, 3);
    flags = (r == 0) ? 8'd0 : (r < 3) ? vtxo_pkg::FLAG_NEEDS_CSUM : 8'($urandom);
    r = $urandom_range(0, 9);
    if (r < 4) gso = 8'd0;
    else if (r < 6) gso = {1'b0, vtxo_pkg::GSO_TCPV4};
    else if (r < 7) gso = {1'b0, vtxo_pkg::GSO_TCPV6};
    else if (r < 8)
      gso = {1'b1, ($urandom_range(0, 1) == 1) ? vtxo_pkg::GSO_TCPV4 : vtxo_pkg::GSO_TCPV6};
    else gso = 8'($urandom);
    l3 = (kind == vtxo_pkg::IP_V4) ? 4 * int'(ihl) :
         (kind == vtxo_pkg::IP_V6) ? int'(vtxo_pkg::V6_HDR_LEN) : 0;
    cs_start = ($urandom_range(0, 3) != 0) ? 16'(l2 + l3) : 16'($urandom);
    if ($urandom_range(0, 4) < 3) begin
      case (proto)
        vtxo_pkg::PROTO_TCP:  cs_ofs = vtxo_pkg::CSUM_OFS_TCP;
        vtxo_pkg::PROTO_UDP:  cs_ofs = vtxo_pkg::CSUM_OFS_UDP;
        vtxo_pkg::PROTO_SCTP: cs_ofs = vtxo_pkg::CSUM_OFS_SCTP;
        default:              cs_ofs = 16'($urandom);
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: cs_ofs = vtxo_pkg::CSUM_OFS_TCP;
        1: cs_ofs = vtxo_pkg::CSUM_OFS_UDP;
        2: cs_ofs = vtxo_pkg::CSUM_OFS_SCTP;
        default: cs_ofs = 16'($urandom);
      endcase
    end
    if (kind == vtxo_pkg::IP_V4) begin
      hdr_end = l2 + 4 * int'(ihl) + 13;
      if (hdr_end < l2 + 10) hdr_end = l2 + 10;
    end else if (kind == vtxo_pkg::IP_V6) begin
      hdr_end = l2 + 53;
    end else begin
      hdr_end = 20;
    end
    r = $urandom_range(0, 19);
    if (r < 14) len = hdr_end + $urandom_range(0, 6);
    else if (r < 17) len = $urandom_range(1, hdr_end);
    else if (r < 19) len = $urandom_range(1, 4);
    else len = $urandom_range(128, 200);
    queue_frame(make_frame(flags, gso, cs_start, cs_ofs, 16'($urandom), vlan, kind, ihl,
                           proto, doff), dbl, len);
  endtask

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 99) == 0) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        track_frame_byte(cur_item);
        sent_bytes++;
        send_gap = pick_gap(send_calm);
      end
      if (!push || !full) begin
        if (drain_marks.size() > 0 && sent_bytes == drain_marks[0] &&
            descriptors_due.size() == 0)
          drain_marks.pop_front();
        holding = drain_marks.size() > 0 && sent_bytes == drain_marks[0];
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (holding || bytes_to_send.size() == 0) begin
          push <= 1'b0;
        end else begin
          cur_item = bytes_to_send.pop_front();
          in_pkt_byte        <= cur_item.pkt_byte;
          in_byte_last       <= cur_item.byte_last;
          in_hdr_flags       <= cur_item.hdr_flags;
          in_hdr_gso_type    <= cur_item.hdr_gso_type;
          in_hdr_csum_start  <= cur_item.hdr_csum_start;
          in_hdr_csum_offset <= cur_item.hdr_csum_offset;
          in_hdr_gso_size    <= cur_item.hdr_gso_size;
          push <= 1'b1;
        end
      end
    end
  end

  // descriptor monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (descriptors_due.size() == 0) begin
          $display("%0t: descriptor with no frame pending, actual l2 %0d l3 %0d l4 %0d",
                   $time, out_l2_length, out_l3_length, out_l4_length);
          mismatches++;
        end else begin
          due = descriptors_due.pop_front();
          field_check("l2_length", due.l2_length, out_l2_length);
          field_check("l3_length", due.l3_length, out_l3_length);
          field_check("l4_length", due.l4_length, out_l4_length);
          field_check("ip_kind", due.ip_kind, out_ip_kind);
          field_check("csum_kind", due.csum_kind, out_csum_kind);
          field_check("tso_on", due.tso_on, out_tso_on);
          field_check("tso_segment_size", due.tso_segment_size, out_tso_segment_size);
          field_check("gso_unsupported", due.gso_unsupported, out_gso_unsupported);
        end
        recv_stall = pick_gap(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // no offload requested, all fields zero
    queue_frame(make_frame(8'd0, 8'd0, 16'd34, vtxo_pkg::CSUM_OFS_TCP, 16'd1460, 1'b0,
                           vtxo_pkg::IP_V4, 4'd5, vtxo_pkg::PROTO_TCP, 4'd5), 1'b0, 60);
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, {1'b0, vtxo_pkg::GSO_TCPV4}, 16'd34,
                           vtxo_pkg::CSUM_OFS_TCP, 16'd1448, 1'b0, vtxo_pkg::IP_V4, 4'd5,
                           vtxo_pkg::PROTO_TCP, 4'd8), 1'b0, 54);
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, 8'd0, 16'd38, vtxo_pkg::CSUM_OFS_UDP,
                           16'd0, 1'b1, vtxo_pkg::IP_V4, 4'd5, vtxo_pkg::PROTO_UDP, 4'd5),
                1'b0, 52);
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, {1'b1, vtxo_pkg::GSO_TCPV6}, 16'd54,
                           vtxo_pkg::CSUM_OFS_SCTP, 16'd9000, 1'b0, vtxo_pkg::IP_V6, 4'd0,
                           vtxo_pkg::PROTO_SCTP, 4'd10), 1'b0, 70);
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, {1'b0, vtxo_pkg::GSO_TCPV6}, 16'd58,
                           vtxo_pkg::CSUM_OFS_TCP, 16'd1200, 1'b1, vtxo_pkg::IP_V6, 4'd0,
                           vtxo_pkg::PROTO_TCP, 4'd15), 1'b0, 72);
    // second vlan tag, segmentation on a non-ip frame
    queue_frame(make_frame(8'd0, {1'b0, vtxo_pkg::GSO_TCPV4}, 16'd18, vtxo_pkg::CSUM_OFS_TCP,
                           16'd512, 1'b1, vtxo_pkg::IP_NONE, 4'd0, vtxo_pkg::PROTO_TCP,
                           4'd5), 1'b1, 30);
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, 8'd3, 16'd14, vtxo_pkg::CSUM_OFS_TCP,
                           16'd100, 1'b0, vtxo_pkg::IP_NONE, 4'd0, vtxo_pkg::PROTO_TCP,
                           4'd5), 1'b0, 20);
    // short frame, ip header cut off
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, {1'b0, vtxo_pkg::GSO_TCPV4}, 16'd34,
                           vtxo_pkg::CSUM_OFS_TCP, 16'd700, 1'b0, vtxo_pkg::IP_V4, 4'd5,
                           vtxo_pkg::PROTO_TCP, 4'd5), 1'b0, 20);
    // long frame, position counter saturates
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, {1'b1, vtxo_pkg::GSO_TCPV4}, 16'd74,
                           vtxo_pkg::CSUM_OFS_TCP, 16'hffff, 1'b0, vtxo_pkg::IP_V4, 4'd15,
                           vtxo_pkg::PROTO_TCP, 4'd15), 1'b0, 200);
    queue_frame(make_frame(8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 1'b0,
                           vtxo_pkg::IP_V4, 4'd15, 8'hff, 4'd15), 1'b0, 1);
    queue_frame(make_frame(8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, vtxo_pkg::IP_NONE, 4'd0,
                           8'd0, 4'd0), 1'b0, 1);
    queue_frame(make_frame(vtxo_pkg::FLAG_NEEDS_CSUM, {1'b0, vtxo_pkg::GSO_TCPV4}, 16'd14,
                           vtxo_pkg::CSUM_OFS_UDP, 16'd64, 1'b0, vtxo_pkg::IP_V4, 4'd0,
                           vtxo_pkg::PROTO_UDP, 4'd7), 1'b0, 40);
    drain_marks.push_back(queued_bytes);

    while (queued_bytes < 1500) begin
      random_frame();
      if (drain_marks.size() == 1 && queued_bytes >= 800) drain_marks.push_back(queued_bytes);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_to_send.size() != 0 || push || descriptors_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && descriptors_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/vtxo_pkg.sv
hdl/vtxo_fifo.sv
hdl/vtxo_front.sv
hdl/vtxo_back.sv
hdl/virtio_tx_offload_header_parser.sv
hdl/vtxo_checker.sv
bench/virtio_tx_offload_header_parser_tb.sv
